/* rtl/nks_pkg.sv */
// shared types and constants for the nearest-k select and mark block
package nks_pkg;

   // width of an entry distance
   localparam int unsigned DIST_W = 32;

   // width of the mode byte and the ready mode register
   localparam int unsigned MODE_W = 8;

   // empty slot value of the kept list
   localparam logic signed [DIST_W-1:0] SENTINEL = 32'sh7FFF_FFFF;

   // ready mode after reset
   localparam logic [MODE_W-1:0] READY_MODE_RST = 8'd2;

   // item kinds
   typedef enum logic {
      REQ_SCAN  = 1'b0,
      REQ_QUERY = 1'b1
   } req_kind_type;

   // control broadcast to every cell of the insertion chain
   typedef struct packed {
      logic update;   // an accepted scan item
      logic clear;    // scan item that starts a run: slots read as empty
      logic insert;   // insert the broadcast distance
   } cell_ctrl_type;

endpackage

/* rtl/nearest_k_select_and_mark.sv */
// Nearest-k select and mark: keeps the KEEP smallest eligible distances of a scan run in a
// chain of KEEP slot cells and answers mark queries against the largest kept value. Every
// cell compares the item's distance with its own slot and shifts from its neighbor in the
// same cycle, so an item is accepted each cycle while req_stall is low, and its result is
// registered in an output register and valid in the next cycle; req_stall rises only while
// that register holds a result that rsp_stall is holding back. The ready mode register is
// written through csr_valid and csr_ready_mode and resets to 2; the user must write it
// only while the block is idle, not enforced by the block. No clearing pass after reset.
module nearest_k_select_and_mark #(
   parameter int unsigned KEEP = 6
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [nks_pkg::MODE_W-1:0]           csr_ready_mode,
   // items in
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_type,
   input  logic                                 req_first_item,
   input  logic                                 req_skip_flag,
   input  logic                                 req_abort_flag,
   input  logic [nks_pkg::MODE_W-1:0]           req_entry_mode,
   input  logic                                 req_has_companion,
   input  logic                                 req_companion_busy,
   input  logic signed [nks_pkg::DIST_W-1:0]    req_distance,
   // results out
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_eligible,
   output logic                                 rsp_mark_far,
   output logic                                 rsp_marking_enabled
);

   localparam int unsigned CNT_W = $clog2(KEEP + 1);
   localparam logic [CNT_W-1:0] KEEP_CNT = CNT_W'(KEEP);

   logic [nks_pkg::MODE_W-1:0] ready_mode_ff;
   logic [nks_pkg::MODE_W-1:0] ready_mode_in;
   logic [CNT_W-1:0]           count_ff;
   logic [CNT_W-1:0]           count_in;
   logic                       abort_ff;
   logic                       abort_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic                       eligible_ff;
   logic                       mark_far_ff;
   logic                       marking_ff;

   logic                       accept;
   logic                       is_scan;
   logic                       elig;
   logic                       far;
   logic                       marking_after;
   nks_pkg::cell_ctrl_type     ctrl;

   logic [KEEP:0]                             lt_chain;
   logic signed [nks_pkg::DIST_W-1:0]         val_chain [KEEP+1];
   logic signed [nks_pkg::DIST_W-1:0]         next_val [KEEP];

   // configuration register
   assign csr_ready     = 1'b1;
   assign ready_mode_in = csr_valid ? csr_ready_mode : ready_mode_ff;

   // handshake: take an item unless a held result blocks the output register
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign is_scan   = nks_pkg::req_kind_type'(req_type) == nks_pkg::REQ_SCAN;

   // eligibility of the item's entry
   assign elig = ~req_skip_flag && (req_entry_mode == ready_mode_ff) &&
                 (~req_has_companion || ~req_companion_busy);

   // cell control for this item, first item only counts on scans
   always_comb begin
      ctrl.update = accept & is_scan;
      ctrl.clear  = is_scan & req_first_item;
      ctrl.insert = elig & ~req_abort_flag;
   end

   // insertion chain
   assign lt_chain[0]  = 1'b0;
   assign val_chain[0] = nks_pkg::SENTINEL;

   for (genvar i = 0; i < KEEP; i++) begin : g_cell
      nks_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .new_dist   (req_distance),
         .prev_lt    (lt_chain[i]),
         .prev_value (val_chain[i]),
         .lt         (lt_chain[i+1]),
         .value      (val_chain[i+1]),
         .value_next (next_val[i])
      );
   end

   // run count and abort flag
   always_comb begin
      count_in = count_ff;
      abort_in = abort_ff;
      if (ctrl.update) begin
         if (req_first_item) begin
            count_in = '0;
            abort_in = 1'b0;
         end
         if (elig) begin
            if (req_abort_flag) begin
               abort_in = 1'b1;
            end else if (count_in < KEEP_CNT) begin
               count_in = count_in + CNT_W'(1);
            end
         end
      end
   end

   // marking state after this item's update
   assign marking_after = ~abort_in && (count_in >= KEEP_CNT) &&
                          (next_val[KEEP-1] != nks_pkg::SENTINEL);

   // far mark for queries, state unchanged by them
   assign far = ~is_scan && elig && ~req_abort_flag && ~abort_ff &&
                (count_ff >= KEEP_CNT) && (val_chain[KEEP] != nks_pkg::SENTINEL) &&
                (val_chain[KEEP] < req_distance);

   // output register
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_mode_ff <= nks_pkg::READY_MODE_RST;
         count_ff      <= '0;
         abort_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         ready_mode_ff <= ready_mode_in;
         count_ff      <= count_in;
         abort_ff      <= abort_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         eligible_ff <= elig;
         mark_far_ff <= far;
         marking_ff  <= marking_after;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_eligible        = eligible_ff;
   assign rsp_mark_far        = mark_far_ff;
   assign rsp_marking_enabled = marking_ff;

endmodule

/* rtl/nks_cell.sv */
// one slot of the sorted insertion chain
module nks_cell (
   input  logic                                 clock,
   input  logic                                 reset,
   input  nks_pkg::cell_ctrl_type               ctrl,
   input  logic signed [nks_pkg::DIST_W-1:0]    new_dist,
   input  logic                                 prev_lt,
   input  logic signed [nks_pkg::DIST_W-1:0]    prev_value,
   output logic                                 lt,
   output logic signed [nks_pkg::DIST_W-1:0]    value,
   output logic signed [nks_pkg::DIST_W-1:0]    value_next
);

   logic signed [nks_pkg::DIST_W-1:0] value_ff;
   logic signed [nks_pkg::DIST_W-1:0] value_in;

   // slot as seen by this item, empty at the start of a run
   assign value = ctrl.clear ? nks_pkg::SENTINEL : value_ff;

   // new distance goes in front of this slot
   assign lt = new_dist < value;

   // shift from the left neighbor, take the new distance, or hold
   always_comb begin
      value_in = value_ff;
      if (ctrl.update) begin
         value_in = value;
         if (ctrl.insert) begin
            priority if (prev_lt) begin
               value_in = prev_value;
            end else if (lt) begin
               value_in = new_dist;
            end
         end
      end
   end

   assign value_next = value_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= nks_pkg::SENTINEL;
      end else begin
         value_ff <= value_in;
      end
   end

endmodule

/* rtl/nks_checker.sv */
// port-level checks for the nearest-k select and mark block
module nks_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_eligible,
   input logic rsp_mark_far,
   input logic rsp_marking_enabled
);

   // a far mark needs an eligible entry
   a_far_elig : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mark_far |-> rsp_eligible)
      else $error("far mark on ineligible entry");

   // a far mark needs marking enabled
   a_far_enabled : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mark_far |-> rsp_marking_enabled)
      else $error("far mark with marking disabled");

   // input is held back only by a waiting result
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without a held result");

   // an accepted item always yields a result next cycle
   a_item_out : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted item gave no result");

   // a held result stays
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_eligible) &&
      $stable(rsp_mark_far) && $stable(rsp_marking_enabled))
      else $error("stalled result changed");

endmodule

bind nearest_k_select_and_mark nks_checker u_nks_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_eligible        (rsp_eligible),
   .rsp_mark_far        (rsp_mark_far),
   .rsp_marking_enabled (rsp_marking_enabled)
);
